[sv/ttb_pkg.sv]
// Package for the timer table bank: command codes, status codes and the
// control/status structs between controller and datapath. No dependencies.
package ttb_pkg;

  typedef enum logic [2:0] {
    OP_CREATE  = 3'd0,
    OP_PEEK    = 3'd1,
    OP_CHECK   = 3'd2,
    OP_EDIT    = 3'd3,
    OP_RESTART = 3'd4,
    OP_KILL    = 3'd5,
    OP_TICK    = 3'd6,
    OP_CLEAR   = 3'd7
  } op_t;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;      // capture the command beat
    logic scan;      // step the scan index and read one entry
    logic finish;    // finish the command and present the result
  } ctrl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_last; // the entry being read is the last one to visit
  } stat_t;

endpackage

[sv/ttb_ctrl.sv]
// Controller of the timer table bank: sequences load, scan and finish.
// Depends on ttb_pkg.
module ttb_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  ttb_pkg::stat_t stat,
  output ttb_pkg::ctrl_t ctrl
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  always_comb begin
    state_next = state;
    ctrl = '0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          ctrl.load = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        ctrl.scan = 1'b1;
        if (stat.scan_last) state_next = S_DONE;
      end
      S_DONE: begin
        ctrl.finish = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

endmodule

[sv/ttb_dpath.sv]
// Datapath of the timer table bank: the three entry memories, the scan over
// them with compaction for kill, and the result registers. Depends on ttb_pkg.
module ttb_dpath #(
  parameter int TABLE_DEPTH = 16,
  parameter int ID_WIDTH    = 16,
  parameter int TIME_WIDTH  = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  ttb_pkg::ctrl_t        ctrl,
  output ttb_pkg::stat_t        stat,
  input  logic [2:0]            op,
  input  logic [15:0]           tmr_id,
  input  logic [31:0]           amount,
  output logic                  done,
  output logic [1:0]            status,
  output logic [31:0]           elapsed,
  output logic                  expired,
  output logic [4:0]            entry_count
);

  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [TIME_WIDTH-1:0] TMAX = '1;

  logic [ID_WIDTH-1:0]   mem_id   [TABLE_DEPTH];
  logic [TIME_WIDTH-1:0] mem_el   [TABLE_DEPTH];
  logic [TIME_WIDTH-1:0] mem_tg   [TABLE_DEPTH];

  logic [2:0]            cmd_op;
  logic [ID_WIDTH-1:0]   cmd_id;
  logic [TIME_WIDTH-1:0] cmd_amt;
  logic [CW-1:0]         used;
  logic [CW-1:0]         rd;      // read pointer of the scan
  logic [CW-1:0]         wr;      // write pointer for compaction
  logic                  found;
  logic [1:0]            res_st;
  logic [TIME_WIDTH-1:0] res_el;
  logic                  res_ex;

  logic [IW-1:0]         ri, wi;
  logic [ID_WIDTH-1:0]   cur_id;
  logic [TIME_WIDTH-1:0] cur_el, cur_tg;
  logic                  in_range, hit, first_hit;
  logic [TIME_WIDTH:0]   sum;
  logic [TIME_WIDTH-1:0] sat;

  assign ri       = rd[IW-1:0];
  assign wi       = wr[IW-1:0];
  assign in_range = (rd < used);
  assign cur_id   = mem_id[ri];
  assign cur_el   = mem_el[ri];
  assign cur_tg   = mem_tg[ri];
  assign hit      = in_range && (cur_id == cmd_id);
  assign first_hit = hit && !found;
  assign sum      = {1'b0, cur_el} + {1'b0, cmd_amt};
  assign sat      = sum[TIME_WIDTH] ? TMAX : sum[TIME_WIDTH-1:0];

  // Create, clear and an empty table need no visit; other ops visit every entry.
  always_comb begin
    stat.scan_last = 1'b1;
    if (cmd_op != ttb_pkg::OP_CREATE && cmd_op != ttb_pkg::OP_CLEAR)
      stat.scan_last = (rd + CW'(1) >= used);
  end

  always_ff @(posedge clk) begin
    if (ctrl.scan) begin
      unique case (cmd_op)
        ttb_pkg::OP_CREATE: begin
          if (used < CW'(TABLE_DEPTH)) begin
            mem_id[used[IW-1:0]] <= cmd_id;
            mem_el[used[IW-1:0]] <= '0;
            mem_tg[used[IW-1:0]] <= cmd_amt;
          end
        end
        ttb_pkg::OP_CHECK: begin
          if (first_hit && cur_tg <= cur_el) mem_el[ri] <= '0;
        end
        ttb_pkg::OP_EDIT: begin
          if (first_hit) mem_tg[ri] <= cmd_amt;
        end
        ttb_pkg::OP_RESTART: begin
          if (first_hit) mem_el[ri] <= '0;
        end
        ttb_pkg::OP_KILL: begin
          if (in_range && !hit) begin
            mem_id[wi] <= cur_id;
            mem_el[wi] <= cur_el;
            mem_tg[wi] <= cur_tg;
          end
        end
        ttb_pkg::OP_TICK: begin
          if (in_range) mem_el[ri] <= sat;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      cmd_op  <= op;
      cmd_id  <= ID_WIDTH'(tmr_id);
      cmd_amt <= TIME_WIDTH'(amount);
      rd      <= '0;
      wr      <= '0;
      res_el  <= '0;
      res_ex  <= 1'b0;
    end
    if (ctrl.scan) begin
      rd <= rd + CW'(1);
      if (in_range && !hit) wr <= wr + CW'(1);
      if (first_hit && cmd_op == ttb_pkg::OP_PEEK) res_el <= cur_el;
      if (first_hit && cmd_op == ttb_pkg::OP_CHECK && cur_tg <= cur_el)
        res_ex <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used  <= '0;
      found <= 1'b0;
      done  <= 1'b0;
    end else begin
      done <= ctrl.finish;
      if (ctrl.load) found <= 1'b0;
      if (ctrl.scan && hit) found <= 1'b1;
      if (ctrl.finish) begin
        res_st <= ttb_pkg::ST_OK;
        unique case (cmd_op)
          ttb_pkg::OP_CREATE: begin
            if (used >= CW'(TABLE_DEPTH)) res_st <= ttb_pkg::ST_FULL;
            else used <= used + CW'(1);
          end
          ttb_pkg::OP_CLEAR: used <= '0;
          ttb_pkg::OP_TICK: ;
          ttb_pkg::OP_KILL: begin
            if (!found) res_st <= ttb_pkg::ST_NOT_FOUND;
            else used <= wr;
          end
          default: if (!found) res_st <= ttb_pkg::ST_NOT_FOUND;
        endcase
      end
    end
  end

  assign status      = res_st;
  assign elapsed     = done ? 32'(res_el) : '0;
  assign expired     = done & res_ex;
  assign entry_count = 5'(used);

endmodule

[sv/timer_table_bank.sv]
// Top level of the timer table bank: joins controller and datapath.
// Depends on ttb_pkg, ttb_ctrl and ttb_dpath.
//
//   channel   signals                               beat taken
//   command   start, op, tmr_id, amount             start && !busy
//   result    done, status, elapsed, expired,       done (one cycle)
//             entry_count
//
// A command passes through the accept cycle, one scan step per held entry
// with at least one scan step, the finish cycle and the result cycle.
// Create and clear take a single step, as does any command on an empty
// table; peek, check, edit, restart, kill and tick walk every held entry
// through the single read port of the entry memories. The result beat
// shows in the cycle after the controller finishes, and busy stays high
// through the result beat and falls after it. Reset empties the table at
// once; entry contents are not cleared. The receiver cannot stall.
module timer_table_bank #(
  parameter int TABLE_DEPTH = 16,
  parameter int ID_WIDTH    = 16,
  parameter int TIME_WIDTH  = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  op,
  input  logic [15:0] tmr_id,
  input  logic [31:0] amount,
  output logic        done,
  output logic [1:0]  status,
  output logic [31:0] elapsed,
  output logic        expired,
  output logic [4:0]  entry_count
);

  ttb_pkg::ctrl_t ctrl;
  ttb_pkg::stat_t stat;
  logic           fsm_busy;

  // Busy also covers the cycle in which the result beat is shown, so a new
  // command never meets a datapath still writing its result.
  ttb_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .start(start && !done),
    .busy (fsm_busy),
    .stat (stat),
    .ctrl (ctrl)
  );

  assign busy = fsm_busy | done;

  ttb_dpath #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .ID_WIDTH   (ID_WIDTH),
    .TIME_WIDTH (TIME_WIDTH)
  ) u_dpath (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (ctrl),
    .stat       (stat),
    .op         (op),
    .tmr_id     (tmr_id),
    .amount     (amount),
    .done       (done),
    .status     (status),
    .elapsed    (elapsed),
    .expired    (expired),
    .entry_count(entry_count)
  );

endmodule

[sv/ttb_check.sv]
// Port-level checker for the timer table bank and its bind.
// Depends on ttb_pkg and timer_table_bank.
module ttb_check (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        done,
  input logic [1:0]  status,
  input logic [31:0] elapsed,
  input logic        expired,
  input logic [4:0]  entry_count
);

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    entry_count <= 5'd16) else $error("entry count beyond table depth");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy) else $error("command taken without busy");

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("result beat longer than one cycle");

  a_miss_quiet: assert property (@(posedge clk) disable iff (rst)
    done && status != ttb_pkg::ST_OK |-> elapsed == 32'd0 && !expired)
    else $error("failed command carries data");

  a_count_stable: assert property (@(posedge clk) disable iff (rst)
    busy && !done && !$past(done) |-> $stable(entry_count))
    else $error("entry count moved mid command");

endmodule

bind timer_table_bank ttb_check u_ttb_check (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done),
  .status(status), .elapsed(elapsed), .expired(expired),
  .entry_count(entry_count)
);
